[rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator
// Payload beats, status codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

  // Region size is tied to the 14-bit offset fields of the beats.
  localparam int REGION_BYTES = 16384;

  typedef struct packed {
    logic        op;
    logic [14:0] request_bytes;
    logic [13:0] payload_offset;
  } in_t;

  typedef struct packed {
    logic [13:0] granted_offset;
    logic [2:0]  status;
  } out_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_ZERO    = 3'd1;
  localparam logic [2:0] STAT_NOFIT   = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_UNKNOWN = 3'd4;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SC_RD,
    S_SC_CHK,
    S_SH_CHK,
    S_SH_WR,
    S_WR_SPLIT,
    S_WR_MAIN,
    S_NX_RD,
    S_NX_CHK,
    S_PV_RD,
    S_PV_CHK,
    S_WR_CUR,
    S_DR_RD,
    S_DR_WR,
    S_FIN
  } state_t;

endpackage

[rtl/ffba_table.sv]
// ----------------------------------------------------------------------------
// ffba_table: block table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator with coalescing
// Keeps an address-ordered block table in a single-port-write memory and
// walks it under a small sequencer for allocate and free requests.
// ----------------------------------------------------------------------------
// Sequence: a zero-size request goes straight to the result; otherwise the
//   sequencer scans table entries one by one, and a split or a merge moves
//   the later entries one at a time.
// Throughput: one request at a time; in_ready is low from acceptance until
//   the result beat is registered, and a stalled result holds the block.
// Reset: synchronous, active low; the init state seeds entry 0, then requests flow.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ffba_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ffba_pkg::out_t out_data
);

  // Offsets and sizes share one width: wide enough for the region and for
  // a request plus a header.
  localparam int RW = $clog2(ffba_pkg::REGION_BYTES + 1);
  localparam int DW = ((RW > 15) ? RW : 15) + 1;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * DW + 1;

  localparam logic [DW-1:0] HDR      = DW'(HEADER_BYTES);
  localparam logic [DW-1:0] INIT_LEN = DW'(ffba_pkg::REGION_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);

  ffba_pkg::state_t state_r, state_nxt;

  logic          op_r, op_nxt;
  logic [DW-1:0] req_r, req_nxt;
  logic [DW-1:0] off_r, off_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] cur_start_r, cur_start_nxt;
  logic [DW-1:0] cur_bytes_r, cur_bytes_nxt;
  logic          drop_ret_r, drop_ret_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [13:0]   granted_r, granted_nxt;
  logic          out_valid_r, out_valid_nxt;
  ffba_pkg::out_t out_data_r, out_data_nxt;

  // Table port
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [DW-1:0] rd_start;
  logic [DW-1:0] rd_bytes;
  logic          rd_free;

  assign rd_free  = rdata[0];
  assign rd_bytes = rdata[DW:1];
  assign rd_start = rdata[2*DW:DW+1];

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready  = (state_r == ffba_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::S_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    idx_r       <= idx_nxt;
    j_r         <= j_nxt;
    cur_start_r <= cur_start_nxt;
    cur_bytes_r <= cur_bytes_nxt;
    drop_ret_r  <= drop_ret_nxt;
    status_r    <= status_nxt;
    granted_r   <= granted_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    cur_start_nxt = cur_start_r;
    cur_bytes_nxt = cur_bytes_r;
    drop_ret_nxt  = drop_ret_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    re    = 1'b0;
    raddr = idx_r;

    // Drop the result beat once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ffba_pkg::S_INIT: begin
        // Seed entry 0 with one free block spanning the region.
        we        = 1'b1;
        waddr     = '0;
        wdata     = {DW'(0), INIT_LEN, 1'b1};
        cnt_nxt   = CW'(1);
        state_nxt = ffba_pkg::S_IDLE;
      end

      ffba_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.op;
          req_nxt     = DW'(in_data.request_bytes);
          off_nxt     = DW'(in_data.payload_offset);
          idx_nxt     = '0;
          granted_nxt = '0;
          if (in_data.op == ffba_pkg::OP_ALLOC && in_data.request_bytes == '0) begin
            status_nxt = ffba_pkg::STAT_ZERO;
            state_nxt  = ffba_pkg::S_FIN;
          end else begin
            state_nxt = ffba_pkg::S_SC_RD;
          end
        end
      end

      ffba_pkg::S_SC_RD: begin
        re        = 1'b1;
        raddr     = idx_r;
        state_nxt = ffba_pkg::S_SC_CHK;
      end

      ffba_pkg::S_SC_CHK: begin
        cur_start_nxt = rd_start;
        cur_bytes_nxt = rd_bytes;
        if (op_r == ffba_pkg::OP_ALLOC) begin
          if (rd_free && rd_bytes >= req_r) begin
            if (rd_bytes > req_r + HDR) begin
              if (cnt_r == CNT_MAX) begin
                status_nxt = ffba_pkg::STAT_FULL;
                state_nxt  = ffba_pkg::S_FIN;
              end else begin
                j_nxt     = cnt_r;
                state_nxt = ffba_pkg::S_SH_CHK;
              end
            end else begin
              state_nxt = ffba_pkg::S_WR_MAIN;
            end
          end else if (CW'(idx_r) + CW'(1) < cnt_r) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = ffba_pkg::S_SC_RD;
          end else begin
            status_nxt = ffba_pkg::STAT_NOFIT;
            state_nxt  = ffba_pkg::S_FIN;
          end
        end else begin
          if (rd_start + HDR == off_r) begin
            if (rd_free) begin
              status_nxt = ffba_pkg::STAT_UNKNOWN;
              state_nxt  = ffba_pkg::S_FIN;
            end else begin
              state_nxt = ffba_pkg::S_NX_RD;
            end
          end else if (CW'(idx_r) + CW'(1) < cnt_r) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = ffba_pkg::S_SC_RD;
          end else begin
            status_nxt = ffba_pkg::STAT_UNKNOWN;
            state_nxt  = ffba_pkg::S_FIN;
          end
        end
      end

      // Open a hole at idx+1 by moving later entries up one at a time.
      ffba_pkg::S_SH_CHK: begin
        if (j_r > CW'(idx_r) + CW'(1)) begin
          re        = 1'b1;
          raddr     = IW'(j_r - CW'(1));
          state_nxt = ffba_pkg::S_SH_WR;
        end else begin
          state_nxt = ffba_pkg::S_WR_SPLIT;
        end
      end

      ffba_pkg::S_SH_WR: begin
        we        = 1'b1;
        waddr     = IW'(j_r);
        wdata     = rdata;
        j_nxt     = j_r - CW'(1);
        state_nxt = ffba_pkg::S_SH_CHK;
      end

      ffba_pkg::S_WR_SPLIT: begin
        we            = 1'b1;
        waddr         = idx_r + IW'(1);
        wdata         = {cur_start_r + HDR + req_r, cur_bytes_r - req_r - HDR, 1'b1};
        cur_bytes_nxt = req_r;
        cnt_nxt       = cnt_r + CW'(1);
        state_nxt     = ffba_pkg::S_WR_MAIN;
      end

      ffba_pkg::S_WR_MAIN: begin
        we          = 1'b1;
        waddr       = idx_r;
        wdata       = {cur_start_r, cur_bytes_r, 1'b0};
        granted_nxt = 14'(cur_start_r + HDR);
        status_nxt  = ffba_pkg::STAT_OK;
        state_nxt   = ffba_pkg::S_FIN;
      end

      // Merge with the following block when it is free.
      ffba_pkg::S_NX_RD: begin
        if (CW'(idx_r) + CW'(1) < cnt_r) begin
          re        = 1'b1;
          raddr     = idx_r + IW'(1);
          state_nxt = ffba_pkg::S_NX_CHK;
        end else begin
          state_nxt = ffba_pkg::S_PV_RD;
        end
      end

      ffba_pkg::S_NX_CHK: begin
        if (rd_free) begin
          cur_bytes_nxt = cur_bytes_r + HDR + rd_bytes;
          j_nxt         = CW'(idx_r) + CW'(1);
          drop_ret_nxt  = 1'b1;
          state_nxt     = ffba_pkg::S_DR_RD;
        end else begin
          state_nxt = ffba_pkg::S_PV_RD;
        end
      end

      // Merge into the preceding block when it is free.
      ffba_pkg::S_PV_RD: begin
        if (idx_r != '0) begin
          re        = 1'b1;
          raddr     = idx_r - IW'(1);
          state_nxt = ffba_pkg::S_PV_CHK;
        end else begin
          state_nxt = ffba_pkg::S_WR_CUR;
        end
      end

      ffba_pkg::S_PV_CHK: begin
        if (rd_free) begin
          we           = 1'b1;
          waddr        = idx_r - IW'(1);
          wdata        = {rd_start, rd_bytes + HDR + cur_bytes_r, 1'b1};
          j_nxt        = CW'(idx_r);
          drop_ret_nxt = 1'b0;
          state_nxt    = ffba_pkg::S_DR_RD;
        end else begin
          state_nxt = ffba_pkg::S_WR_CUR;
        end
      end

      ffba_pkg::S_WR_CUR: begin
        we         = 1'b1;
        waddr      = idx_r;
        wdata      = {cur_start_r, cur_bytes_r, 1'b1};
        status_nxt = ffba_pkg::STAT_OK;
        state_nxt  = ffba_pkg::S_FIN;
      end

      // Remove entry j by moving later entries down one at a time.
      ffba_pkg::S_DR_RD: begin
        if (j_r + CW'(1) < cnt_r) begin
          re        = 1'b1;
          raddr     = IW'(j_r + CW'(1));
          state_nxt = ffba_pkg::S_DR_WR;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          if (drop_ret_r) begin
            state_nxt = ffba_pkg::S_PV_RD;
          end else begin
            status_nxt = ffba_pkg::STAT_OK;
            state_nxt  = ffba_pkg::S_FIN;
          end
        end
      end

      ffba_pkg::S_DR_WR: begin
        we        = 1'b1;
        waddr     = IW'(j_r);
        wdata     = rdata;
        j_nxt     = j_r + CW'(1);
        state_nxt = ffba_pkg::S_DR_RD;
      end

      // Hold until the output register is free, then load the beat.
      ffba_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.granted_offset = granted_r;
          out_data_nxt.status         = status_r;
          state_nxt                   = ffba_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

[rtl/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker: port-level checks of the first-fit block allocator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ffba_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ffba_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ffba_pkg::STAT_OK |-> out_data.granted_offset == '0)
    else $error("refused request carries an offset");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ffba_pkg::STAT_UNKNOWN)
    else $error("status code out of range");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/tb_first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator: self-checking bench of the block allocator
// Drives allocate and free beats, predicts every status and granted offset
// with a behavioural copy of the block table, and checks each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

  localparam int REGION = 16384;
  localparam int HDR    = 24;
  localparam int NBLK   = 64;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  ffba_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  ffba_pkg::out_t out_data;

  first_fit_block_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Behavioural copy of the block table
  int unsigned hdr_at [NBLK];
  int unsigned size_of[NBLK];
  bit          is_free[NBLK];
  int unsigned n_blocks;

  ffba_pkg::out_t pending_results[$];
  int unsigned live_offsets[$];   // payload offsets currently handed out
  int          mismatches;
  bit          send_gaps;         // sender idles at random
  bit          recv_gaps;         // receiver stalls at random
  int          hold_off;          // receiver long stall, in cycles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  task automatic table_reset();
    for (int k = 0; k < NBLK; k++) begin
      hdr_at[k] = 0;
      size_of[k] = 0;
      is_free[k] = 1'b0;
    end
    size_of[0] = REGION - HDR;
    is_free[0] = 1'b1;
    n_blocks   = 1;
  endtask

  // Remove entry k, shifting later entries down
  function automatic void drop_block(int unsigned k);
    for (int unsigned j = k; j + 1 < n_blocks; j++) begin
      hdr_at[j]  = hdr_at[j+1];
      size_of[j] = size_of[j+1];
      is_free[j] = is_free[j+1];
    end
    n_blocks--;
    hdr_at[n_blocks]  = 0;
    size_of[n_blocks] = 0;
    is_free[n_blocks] = 1'b0;
  endfunction

  function automatic void merge_into(int unsigned k);
    size_of[k] = size_of[k] + HDR + size_of[k+1];
    drop_block(k + 1);
  endfunction

  // Apply one request to the table copy and return the result it gives
  function automatic ffba_pkg::out_t predict_allocator(ffba_pkg::in_t req);
    ffba_pkg::out_t r;
    int unsigned    i;
    int unsigned    want;
    r.granted_offset = '0;
    r.status         = ffba_pkg::STAT_OK;
    if (req.op == ffba_pkg::OP_ALLOC) begin
      want = req.request_bytes;
      if (want == 0) begin
        r.status = ffba_pkg::STAT_ZERO;
        return r;
      end
      for (i = 0; i < n_blocks; i++)
        if (is_free[i] && size_of[i] >= want) break;
      if (i >= n_blocks) begin
        r.status = ffba_pkg::STAT_NOFIT;
        return r;
      end
      if (size_of[i] > want + HDR) begin
        if (n_blocks >= NBLK) begin
          r.status = ffba_pkg::STAT_FULL;
          return r;
        end
        for (int unsigned j = n_blocks; j > i + 1; j--) begin
          hdr_at[j]  = hdr_at[j-1];
          size_of[j] = size_of[j-1];
          is_free[j] = is_free[j-1];
        end
        hdr_at[i+1]  = hdr_at[i] + HDR + want;
        size_of[i+1] = size_of[i] - want - HDR;
        is_free[i+1] = 1'b1;
        size_of[i]   = want;
        n_blocks++;
      end
      is_free[i] = 1'b0;
      r.granted_offset = 14'(hdr_at[i] + HDR);
      live_offsets.push_back(hdr_at[i] + HDR);
    end else begin
      for (i = 0; i < n_blocks; i++)
        if (hdr_at[i] + HDR == req.payload_offset) break;
      if (i >= n_blocks || is_free[i]) begin
        r.status = ffba_pkg::STAT_UNKNOWN;
        return r;
      end
      is_free[i] = 1'b1;
      foreach (live_offsets[q])
        if (live_offsets[q] == req.payload_offset) begin
          live_offsets.delete(q);
          break;
        end
      if (i + 1 < n_blocks && is_free[i+1]) merge_into(i);
      if (i > 0 && is_free[i-1]) merge_into(i - 1);
    end
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then predict its result
  task automatic send_request(logic op, int unsigned bytes, int unsigned off);
    ffba_pkg::in_t b;
    if (send_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) @(negedge clk);
    b.op             = op;
    b.request_bytes  = 15'(bytes);
    b.payload_offset = 14'(off);
    in_data  = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_allocator(b));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_alloc(int unsigned bytes);
    send_request(ffba_pkg::OP_ALLOC, bytes, $urandom_range(0, 16383));
  endtask

  task automatic send_free(int unsigned off);
    send_request(ffba_pkg::OP_FREE, $urandom_range(0, 32767), off);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Free a random live block, or a random offset
  task automatic free_something();
    int q;
    if (live_offsets.size() != 0 && $urandom_range(0, 9) != 0) begin
      q = $urandom_range(0, live_offsets.size() - 1);
      send_free(live_offsets[q]);
    end else begin
      send_free($urandom_range(0, 16383));
    end
  endtask

  // Result checker: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    ffba_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: offset %0d status %0d",
                   out_data.granted_offset, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (want.granted_offset !== out_data.granted_offset ||
            want.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected offset %0d status %0d, got %0d %0d",
                     want.granted_offset, want.status,
                     out_data.granted_offset, out_data.status);
        end
      end
    end
  end

  // Receiver: long hold-off on request, else random stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_edges();
    send_alloc(0);                       // zero size
    send_alloc(16384);                   // no fit, too big
    send_alloc(32767);                   // all request bits high
    send_free(0);                        // unknown address
    send_free(16383);
    send_alloc(REGION - HDR);            // exact fit of whole region
    send_alloc(1);                       // no fit, region taken
    send_free(HDR);
    send_free(HDR);                      // double free
    send_alloc(REGION - 2 * HDR - 1);    // near fit, splits off one byte
    send_free(HDR);
    send_alloc(100);                     // split
    send_alloc(200);
    send_alloc(300);
    send_free(HDR + 100 + HDR);          // middle block
    send_free(HDR);                      // merge with next
    send_free(HDR + 100 + HDR + 200 + HDR); // merge both sides
    send_alloc(1);
    send_free(HDR);
    wait_drained();
  endtask

  // Fill the table with tiny blocks to reach table full
  task automatic test_table_full();
    for (int k = 0; k < NBLK + 2; k++) send_alloc($urandom_range(1, 8));
    send_alloc(8);
    while (live_offsets.size() != 0) send_free(live_offsets[0]);
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_off = 300;
    for (int k = 0; k < 20; k++) send_alloc($urandom_range(1, 64));
    wait_drained();
    while (live_offsets.size() != 0) send_free(live_offsets[0]);
    wait_drained();
  endtask

  task automatic test_random(int count, bit gaps);
    int r;
    send_gaps = gaps;
    recv_gaps = gaps;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        case ($urandom_range(0, 5))
          0:       send_alloc($urandom_range(0, 32767));
          1:       send_alloc($urandom_range(1, 4096));
          default: send_alloc($urandom_range(1, 300));
        endcase
      end else begin
        free_something();
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    mismatches = 0;
    hold_off   = 0;
    send_gaps  = 1'b1;
    recv_gaps  = 1'b1;
    table_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edges();
    test_table_full();
    test_backpressure();
    test_random(250, 1'b1);
    test_random(100, 1'b0);

    repeat (500) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
tb/sv/tb_first_fit_block_allocator.sv
